FILE: rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg: shared types and constants of the positional list engine
// Command and status codes, field widths and the control word that the
// sequencer broadcasts to every list cell.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CMD_W    = 3;
  localparam int VAL_W    = 32;
  localparam int POS_IN_W = 8;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND   = 3'd0,
    CMD_INSERT   = 3'd1,
    CMD_SEARCH   = 3'd2,
    CMD_DEL_LAST = 3'd3,
    CMD_DEL_AT   = 3'd4,
    CMD_READ     = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOPOS    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  // What every cell does on a clock edge, as the sequencer broadcasts it.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ROTATE,
    CELL_SHIFT,
    CELL_MARK
  } cell_op_e;

  typedef struct packed {
    cell_op_e                op;
    logic signed [VAL_W-1:0] data;
  } cell_ctl_t;

endpackage

FILE: rtl/ple_if.sv
// ----------------------------------------------------------------------------
// ple_if: handshake channels of the positional list engine
// One interface for commands and one for results, each with valid, ready
// and the payload fields.
// ----------------------------------------------------------------------------
interface ple_in_if import ple_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           cmd;
  logic signed [VAL_W-1:0]    value;
  logic [POS_IN_W-1:0]        position;

  modport source (output valid, cmd, value, position, input ready);
  modport sink   (input valid, cmd, value, position, output ready);
endinterface

interface ple_out_if import ple_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic [POS_W-1:0]           found_position;
  logic signed [VAL_W-1:0]    entry_value;
  logic                       last;

  modport source (output valid, status, found_position, entry_value, last, input ready);
  modport sink   (input valid, status, found_position, entry_value, last, output ready);
endinterface

FILE: rtl/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell: one slot of the list chain
// Holds one value and a match flag. Takes the new value or data from its left
// neighbor on an insert, from its right neighbor on a rotate or shift, and
// from the head cell when it is the tail of a rotate.
// ----------------------------------------------------------------------------
module ple_cell import ple_pkg::*; #(
  parameter int IW = 4,
  parameter int CW = 5
) (
  input  logic                    clk_i,
  input  cell_ctl_t               ctl_i,
  input  logic [IW-1:0]           idx_i,
  input  logic [IW-1:0]           pos_i,
  input  logic [CW-1:0]           count_i,
  input  logic signed [VAL_W-1:0] prev_val_i,
  input  logic signed [VAL_W-1:0] next_val_i,
  input  logic                    next_flag_i,
  input  logic signed [VAL_W-1:0] head_val_i,
  output logic signed [VAL_W-1:0] val_o,
  output logic                    flag_o,
  output logic                    hit_o
);

  logic signed [VAL_W-1:0] val_q;
  logic                    flag_q;
  logic                    in_list;
  logic                    is_tail;

  assign in_list = CW'(idx_i) < count_i;
  assign is_tail = CW'(idx_i) == (count_i - CW'(1));
  assign hit_o   = in_list && (val_q == ctl_i.data);
  assign val_o   = val_q;
  assign flag_o  = flag_q;

  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      CELL_INSERT: begin
        if (idx_i == pos_i) begin
          val_q <= ctl_i.data;
        end else if (idx_i > pos_i) begin
          val_q <= prev_val_i;
        end
      end
      CELL_ROTATE: begin
        // The tail closes the ring; a visited entry comes back unflagged.
        if (is_tail) begin
          val_q  <= head_val_i;
          flag_q <= 1'b0;
        end else begin
          val_q  <= next_val_i;
          flag_q <= next_flag_i;
        end
      end
      CELL_SHIFT: begin
        val_q  <= next_val_i;
        flag_q <= next_flag_i;
      end
      CELL_MARK: begin
        flag_q <= hit_o;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine: bounded ordered list of signed 32-bit values
// Commands append, insert, search, delete and read out a list kept in a
// chain of cells, entry 0 at the head.
// ----------------------------------------------------------------------------
//
//   Channel | Modport           | Transaction
//   --------+-------------------+---------------------------------------------
//   in_i    | ple_in_if.sink    | one command: cmd, value, position
//   out_o   | ple_out_if.source | one result: status, found_position,
//           |                   |   entry_value, last
//
// Append, insert and every error give one result straight from the command.
// Search, read-out and both deletes accept the command and then rotate the
// chain once through the head cell, one entry per cycle, holding an entry at
// the head while its result is due and the result port is stalled.
// A new command is taken once the previous one has finished and the output
// register is free or being emptied.
// Reset clears the entry count and the sequencer; cell contents keep no reset.
module positional_list_engine import ple_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ple_in_if.sink     in_i,
  ple_out_if.source  out_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  typedef enum logic [1:0] {
    RUN_SEARCH,
    RUN_READ,
    RUN_DELETE
  } run_op_e;

  state_e              state_q, state_d;
  run_op_e             run_op_q, run_op_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       total_q, total_d;
  logic [CW-1:0]       step_q, step_d;
  logic [CW-1:0]       del_idx_q, del_idx_d;

  logic                    out_valid_q;
  logic [STATUS_W-1:0]     out_status_q;
  logic [POS_W-1:0]        out_pos_q;
  logic signed [VAL_W-1:0] out_val_q;
  logic                    out_last_q;

  cell_ctl_t               ctl;
  logic [IW-1:0]           cell_pos;
  logic signed [VAL_W-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]     flag_vec;
  logic [CAPACITY-1:0]     hit_vec;

  logic                    out_free;
  logic                    accept;
  logic                    emit;
  status_e                 e_status;
  logic [POS_W-1:0]        e_pos;
  logic signed [VAL_W-1:0] e_val;
  logic                    e_last;

  logic                    full;
  logic [POS_IN_W:0]       pos_ext;
  logic [POS_IN_W:0]       cnt_ext;
  logic [CW-1:0]           ins_idx;
  logic                    is_final;
  logic                    drop;
  logic                    need;
  logic                    rest_flags;

  // Cell chain.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [VAL_W-1:0] prev_val;
    logic signed [VAL_W-1:0] next_val;
    logic                    next_flag;

    if (g == 0) begin : g_head
      assign prev_val = '0;
    end else begin : g_body
      assign prev_val = cell_val[g-1];
    end

    if (g == CAPACITY - 1) begin : g_end
      assign next_val  = '0;
      assign next_flag = 1'b0;
    end else begin : g_mid
      assign next_val  = cell_val[g+1];
      assign next_flag = flag_vec[g+1];
    end

    ple_cell #(
      .IW (IW),
      .CW (CW)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .idx_i       (IW'(g)),
      .pos_i       (cell_pos),
      .count_i     (count_q),
      .prev_val_i  (prev_val),
      .next_val_i  (next_val),
      .next_flag_i (next_flag),
      .head_val_i  (cell_val[0]),
      .val_o       (cell_val[g]),
      .flag_o      (flag_vec[g]),
      .hit_o       (hit_vec[g])
    );
  end

  assign out_free   = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && out_free;
  assign accept     = in_i.valid && in_i.ready;

  assign full       = count_q == CW'(CAPACITY);
  assign pos_ext    = {1'b0, in_i.position};
  assign cnt_ext    = (POS_IN_W + 1)'(count_q);
  assign is_final   = step_q == (total_q - CW'(1));
  assign drop       = (run_op_q == RUN_DELETE) && (step_q == del_idx_q);
  assign rest_flags = |flag_vec[CAPACITY-1:1];

  always_comb begin
    state_d   = state_q;
    run_op_d  = run_op_q;
    count_d   = count_q;
    total_d   = total_q;
    step_d    = step_q;
    del_idx_d = del_idx_q;
    ctl.op    = CELL_HOLD;
    ctl.data  = in_i.value;
    cell_pos  = '0;
    ins_idx   = '0;
    need      = 1'b0;
    emit      = 1'b0;
    e_status  = ST_OK;
    e_pos     = '0;
    e_val     = '0;
    e_last    = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd_e'(in_i.cmd))
            CMD_APPEND, CMD_INSERT: begin
              // Positions past the end, up to one beyond it, append.
              if (in_i.cmd == CMD_APPEND || pos_ext > cnt_ext) begin
                ins_idx = count_q;
              end else begin
                ins_idx = CW'(in_i.position);
              end
              emit = 1'b1;
              if (full) begin
                e_status = ST_FULL;
              end else if (in_i.cmd == CMD_INSERT && pos_ext > cnt_ext + 1'b1) begin
                e_status = ST_NOPOS;
              end else begin
                ctl.op   = CELL_INSERT;
                cell_pos = ins_idx[IW-1:0];
                count_d  = count_q + CW'(1);
                e_pos    = POS_W'(ins_idx) + POS_W'(1);
                e_val    = in_i.value;
              end
            end
            CMD_SEARCH: begin
              if (|hit_vec) begin
                ctl.op   = CELL_MARK;
                run_op_d = RUN_SEARCH;
                total_d  = count_q;
                step_d   = '0;
                state_d  = S_RUN;
              end else begin
                emit     = 1'b1;
                e_status = ST_NOTFOUND;
              end
            end
            CMD_DEL_LAST: begin
              if (count_q == '0) begin
                emit     = 1'b1;
                e_status = ST_EMPTY;
              end else begin
                run_op_d  = RUN_DELETE;
                del_idx_d = count_q - CW'(1);
                total_d   = count_q;
                step_d    = '0;
                state_d   = S_RUN;
              end
            end
            CMD_DEL_AT: begin
              if (in_i.position == '0) begin
                emit     = 1'b1;
                e_status = ST_NOPOS;
              end else if (count_q == '0) begin
                emit     = 1'b1;
                e_status = ST_EMPTY;
              end else if (pos_ext > cnt_ext) begin
                emit     = 1'b1;
                e_status = ST_NOPOS;
              end else begin
                run_op_d  = RUN_DELETE;
                del_idx_d = CW'(in_i.position) - CW'(1);
                total_d   = count_q;
                step_d    = '0;
                state_d   = S_RUN;
              end
            end
            CMD_READ: begin
              if (count_q == '0) begin
                emit     = 1'b1;
                e_status = ST_EMPTY;
              end else begin
                run_op_d = RUN_READ;
                total_d  = count_q;
                step_d   = '0;
                state_d  = S_RUN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RUN: begin
        case (run_op_q)
          RUN_READ: begin
            need   = 1'b1;
            e_last = is_final;
          end
          RUN_SEARCH: begin
            need   = flag_vec[0];
            e_last = !rest_flags;
          end
          RUN_DELETE: begin
            need   = drop;
            e_last = 1'b1;
          end
          default: begin
          end
        endcase
        e_pos = POS_W'(step_q) + POS_W'(1);
        e_val = cell_val[0];
        // The head steps on unless a result is due and the port is stalled.
        if (!need || out_free) begin
          emit   = need;
          ctl.op = drop ? CELL_SHIFT : CELL_ROTATE;
          step_d = step_q + CW'(1);
          if (drop) begin
            count_d = count_q - CW'(1);
          end
          if (is_final) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      run_op_q    <= RUN_READ;
      count_q     <= '0;
      total_q     <= '0;
      step_q      <= '0;
      del_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      run_op_q  <= run_op_d;
      count_q   <= count_d;
      total_q   <= total_d;
      step_q    <= step_d;
      del_idx_q <= del_idx_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_status_q <= e_status;
      out_pos_q    <= e_pos;
      out_val_q    <= e_val;
      out_last_q   <= e_last;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_status_q;
  assign out_o.found_position = out_pos_q;
  assign out_o.entry_value    = out_val_q;
  assign out_o.last           = out_last_q;

endmodule

FILE: rtl/ple_checker.sv
// ----------------------------------------------------------------------------
// ple_checker: port-level checks of the positional list engine
// Watches the command and result channels and flags results or handshakes
// that the engine must never show.
// ----------------------------------------------------------------------------
module ple_checker import ple_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [STATUS_W-1:0] status_i,
  input logic [POS_W-1:0]    found_position_i,
  input logic                last_i
);

  // A failed command answers with one closing result carrying no position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != ST_OK) |-> last_i && (found_position_i == '0))
    else $error("error result without last or with a position");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (status_i <= ST_NOTFOUND))
    else $error("undefined status code");

  // No new command is taken while a result waits on a stalled port.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("command taken while a result is stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i)
      && $stable(found_position_i) && $stable(last_i))
    else $error("stalled result changed");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .status_i         (out_o.status),
  .found_position_i (out_o.found_position),
  .last_i           (out_o.last)
);
